FILE: hdl/anxb_pkg.sv
package anxb_pkg;

   // Byte codes seen in an Annex B stream
   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ONE  = 8'h01;
   localparam logic [7:0] BYTE_EPB  = 8'h03;  // emulation prevention byte

   // Zero run saturates at three
   localparam logic [1:0] RUN_SHORT = 2'd2;
   localparam logic [1:0] RUN_LONG  = 2'd3;

   // Most result bytes one input byte can release
   localparam int MAX_RESULTS = 4;
   localparam int NUM_W       = $clog2(MAX_RESULTS + 1);
   localparam int SLOT_W      = $clog2(MAX_RESULTS);

   // Result queue
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Queue count limit for a new byte, with and without a byte in the input stage
   localparam logic [CNT_W-1:0] LIMIT_IDLE = CNT_W'(QUEUE_DEPTH - MAX_RESULTS);
   localparam logic [CNT_W-1:0] LIMIT_BUSY = CNT_W'(QUEUE_DEPTH - 2 * MAX_RESULTS);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       first_of_unit;
      logic       last_of_unit;
      logic       long_start_code;
   } result_type;

   typedef struct packed {
      logic [NUM_W-1:0]                   num;
      result_type [MAX_RESULTS-1:0]       item;
   } push_type;

endpackage

FILE: hdl/anxb_parser.sv
module anxb_parser import anxb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic [7:0] data_byte,
   input  logic       end_of_stream,
   output logic       busy,
   output push_type   push
);

   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             in_eos_ff;

   logic             inside_ff,     inside_in;
   logic [1:0]       zero_run_ff,   zero_run_in;
   logic             held_valid_ff, held_valid_in;
   logic [7:0]       held_byte_ff,  held_byte_in;
   logic             held_first_ff, held_first_in;
   logic             long_ff,       long_in;

   logic [NUM_W-1:0]             num;
   result_type [MAX_RESULTS-1:0] items;
   logic [1:0]                   zero_cnt;
   logic                         drop_epb;
   logic                         do_commit;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         inside_ff     <= 1'b0;
         zero_run_ff   <= '0;
         held_valid_ff <= 1'b0;
         held_first_ff <= 1'b0;
         long_ff       <= 1'b0;
      end else begin
         in_valid_ff <= load;
         if (in_valid_ff) begin
            inside_ff     <= inside_in;
            zero_run_ff   <= zero_run_in;
            held_valid_ff <= held_valid_in;
            held_first_ff <= held_first_in;
            long_ff       <= long_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_byte_ff <= data_byte;
         in_eos_ff  <= end_of_stream;
      end
      if (in_valid_ff) begin
         held_byte_ff <= held_byte_in;
      end
   end

   always_comb begin
      inside_in     = inside_ff;
      zero_run_in   = zero_run_ff;
      held_valid_in = held_valid_ff;
      held_byte_in  = held_byte_ff;
      held_first_in = held_first_ff;
      long_in       = long_ff;
      num           = '0;
      items         = '0;
      zero_cnt      = '0;
      drop_epb      = 1'b0;
      do_commit     = 1'b0;

      priority if (in_byte_ff == BYTE_ZERO) begin
         if (zero_run_in != RUN_LONG) zero_run_in = zero_run_in + 2'd1;
      end else if (in_byte_ff == BYTE_ONE && zero_run_in >= RUN_SHORT) begin
         // start code: close the unit in progress
         if (held_valid_in) begin
            items[num[SLOT_W-1:0]] = '{held_byte_in, held_first_in, 1'b1, long_in};
            num = num + NUM_W'(1);
         end
         held_valid_in = 1'b0;
         inside_in     = 1'b1;
         long_in       = (zero_run_in == RUN_LONG);
         held_first_in = 1'b0;
         zero_run_in   = '0;
      end else begin
         // pending zeros (at most two) then the byte, unless an EPB after 00 00
         zero_cnt = (zero_run_in >= RUN_SHORT) ? RUN_SHORT : zero_run_in;
         drop_epb = (in_byte_ff == BYTE_EPB) && (zero_run_in >= RUN_SHORT);
         for (int j = 0; j < 3; j++) begin
            do_commit = (2'(j) < zero_cnt) || ((2'(j) == zero_cnt) && !drop_epb);
            if (do_commit && inside_in) begin
               if (held_valid_in) begin
                  items[num[SLOT_W-1:0]] = '{held_byte_in, held_first_in, 1'b0, long_in};
                  num = num + NUM_W'(1);
               end
               held_first_in = !held_valid_in;
               held_byte_in  = (2'(j) < zero_cnt) ? BYTE_ZERO : in_byte_ff;
               held_valid_in = 1'b1;
            end
         end
         zero_run_in = '0;
      end

      if (in_eos_ff) begin
         // pending zeros are trailing zeros; flush the held byte
         if (inside_in && held_valid_in) begin
            items[num[SLOT_W-1:0]] = '{held_byte_in, held_first_in, 1'b1, long_in};
            num = num + NUM_W'(1);
         end
         inside_in     = 1'b0;
         zero_run_in   = '0;
         held_valid_in = 1'b0;
         held_byte_in  = BYTE_ZERO;
         held_first_in = 1'b0;
         long_in       = 1'b0;
      end
   end

   assign push.num  = in_valid_ff ? num : '0;
   assign push.item = items;
   assign busy      = in_valid_ff;

   a_no_hold_outside: assert property (@(posedge clock) disable iff (reset)
      !inside_ff |-> !held_valid_ff)
      else $error("held byte outside a unit");

   a_no_push_outside: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !inside_ff && !(in_byte_ff == BYTE_ONE && zero_run_ff >= RUN_SHORT))
      |-> (push.num == '0))
      else $error("output before the first start code");

   a_push_bound: assert property (@(posedge clock) disable iff (reset)
      push.num <= NUM_W'(MAX_RESULTS))
      else $error("too many results for one byte");

endmodule

FILE: hdl/anxb_fifo.sv
module anxb_fifo import anxb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop_ready,
   output logic             head_valid,
   output result_type       head,
   output logic [CNT_W-1:0] count
);

   result_type             mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff,  count_in;
   logic                   pop;

   assign head_valid = (count_ff != '0);
   assign pop        = head_valid && pop_ready;
   assign head       = mem_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.num);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.num) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (NUM_W'(i) < push.num) mem_ff[wr_ptr_ff + PTR_W'(i)] <= push.item[i];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count past depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (CNT_W + 1)'(count_ff) + (CNT_W + 1)'(push.num) <= (CNT_W + 1)'(QUEUE_DEPTH))
      else $error("queue overflow");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 && push.num != '0) |=> head_valid)
      else $error("pushed result not visible");

endmodule

FILE: hdl/annexb_nal_unit_extractor_top.sv
// Channel  | Dir | tdata               | tuser                              | tlast
// ---------+-----+---------------------+------------------------------------+---------------
// req_     | in  | [7:0] data_byte     | -                                  | end_of_stream
// rsp_     | out | [7:0] out_byte      | [0] first_of_unit [1] long_start   | last_of_unit
//
// One byte per cycle in: a byte is registered at transfer and parsed in the next cycle.
// Parsing one byte pushes 0 to 4 result bytes into a 16-entry queue; results leave one
// per cycle with rsp_tready high; input takes a byte per cycle while the queue keeps up.
// req_tready drops when the queue could not take a worst-case burst (4 free slots per
// byte in flight); rsp stalls never block the parser directly.
// Synchronous active-high reset empties the queue and returns to the no-start-code state.
module annexb_nal_unit_extractor_top import anxb_pkg::*; (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // end_of_stream

   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] first_of_unit, [1] long_start_code
   output logic       rsp_tlast    // last_of_unit
);

   push_type         push;
   logic             busy;
   result_type       head;
   logic [CNT_W-1:0] count;
   logic             load;

   // Worst case the byte in the input stage and the new one each push four results
   assign req_tready = busy ? (count <= LIMIT_BUSY) : (count <= LIMIT_IDLE);
   assign load       = req_tvalid && req_tready;

   anxb_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .data_byte     (req_tdata),
      .end_of_stream (req_tlast),
      .busy          (busy),
      .push          (push)
   );

   anxb_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop_ready  (rsp_tready),
      .head_valid (rsp_tvalid),
      .head       (head),
      .count      (count)
   );

   assign rsp_tdata = head.out_byte;
   assign rsp_tuser = {head.long_start_code, head.first_of_unit};
   assign rsp_tlast = head.last_of_unit;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import anxb_pkg::*;

   localparam int RANDOM_BYTES = 190;
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, enough to fill the queue
   localparam int QUIET_LIMIT  = 2000;  // cycles without any transfer before giving up
   localparam int SETTLE       = 20;    // extra cycles after the last expected byte

   // Byte-level model of the extractor plus the queue of NAL bytes it predicts.
   class nal_scoreboard;
      logic       in_unit;
      logic [1:0] zero_count;
      logic       held_ok;
      logic [7:0] held_value;
      logic       held_first;
      logic       long_code;
      result_type due_bytes[$];
      int         errors;
      int         matched;

      function new();
         errors  = 0;
         matched = 0;
         clear();
      endfunction

      function void clear();
         in_unit    = 1'b0;
         zero_count = '0;
         held_ok    = 1'b0;
         held_value = '0;
         held_first = 1'b0;
         long_code  = 1'b0;
      endfunction

      function void predict_byte(logic [7:0] b, logic first, logic last);
         result_type r;
         r.out_byte        = b;
         r.first_of_unit   = first;
         r.last_of_unit    = last;
         r.long_start_code = long_code;
         due_bytes.push_back(r);
      endfunction

      // one payload byte is always held back so the unit's last byte can be flagged
      function void commit_byte(logic [7:0] x);
         if (!in_unit) return;
         if (held_ok) predict_byte(held_value, held_first, 1'b0);
         held_first = !held_ok;
         held_value = x;
         held_ok    = 1'b1;
      endfunction

      function void close_unit();
         if (held_ok) predict_byte(held_value, held_first, 1'b1);
         held_ok = 1'b0;
      endfunction

      function void note_stream_byte(logic [7:0] b, logic eos);
         logic [1:0] keep;
         if (b == BYTE_ZERO) begin
            if (zero_count != RUN_LONG) zero_count++;
         end else if (b == BYTE_ONE && zero_count >= RUN_SHORT) begin
            close_unit();
            in_unit    = 1'b1;
            long_code  = (zero_count == RUN_LONG);
            held_first = 1'b0;
            zero_count = '0;
         end else begin
            // at most two pending zeros survive; older ones are trailing zeros
            keep = (zero_count >= RUN_SHORT) ? RUN_SHORT : zero_count;
            for (int i = 0; i < keep; i++) commit_byte(BYTE_ZERO);
            if (!(b == BYTE_EPB && zero_count >= RUN_SHORT)) commit_byte(b);
            zero_count = '0;
         end
         if (eos) begin
            if (in_unit) close_unit();
            clear();
         end
      endfunction

      function void check_nal_byte(result_type got);
         result_type want;
         if (due_bytes.size() == 0) begin
            $error("unexpected NAL byte %0h, nothing pending", got.out_byte);
            errors++;
            return;
         end
         want = due_bytes.pop_front();
         matched++;
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
            errors++;
         end
         if (got.first_of_unit !== want.first_of_unit) begin
            $error("first_of_unit: expected %0b, actual %0b",
                   want.first_of_unit, got.first_of_unit);
            errors++;
         end
         if (got.last_of_unit !== want.last_of_unit) begin
            $error("last_of_unit: expected %0b, actual %0b",
                   want.last_of_unit, got.last_of_unit);
            errors++;
         end
         if (got.long_start_code !== want.long_start_code) begin
            $error("long_start_code: expected %0b, actual %0b",
                   want.long_start_code, got.long_start_code);
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;

   nal_scoreboard sb;
   bit  calm;            // both sides stop idling while set
   bit  hold_request;    // asks the receiver for one long hold-off
   int  bytes_sent;
   int  units_sent;
   int  flushes;
   int  quiet_cycles;

   annexb_nal_unit_extractor_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Offer one stream byte, with occasional idle cycles before it; returns at the
   // edge of its transfer. tvalid stays high into the next call unless it idles.
   task automatic send_byte(input logic [7:0] b, input logic eos);
      while (!calm && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      sb.note_stream_byte(b, eos);
      bytes_sent++;
      if (eos) flushes++;
   endtask

   // Payload content leans on the bytes that matter to the parser: 00, 01, 02, 03.
   function automatic logic [7:0] payload_byte();
      int r;
      r = $urandom_range(99);
      if (r < 25) return BYTE_ZERO;
      if (r < 30) return BYTE_ONE;
      if (r < 34) return 8'h02;
      if (r < 38) return BYTE_EPB;
      return 8'($urandom_range(255));
   endfunction

   // Start code (short, long, or padded with extra zeros) followed by payload.
   // With ends_stream the last byte sent carries the end-of-stream flag.
   task automatic send_unit(input int len, input bit ends_stream);
      int lead;
      lead = ($urandom_range(99) < 15) ? $urandom_range(6, 4) : $urandom_range(3, 2);
      repeat (lead) send_byte(BYTE_ZERO, 1'b0);
      send_byte(BYTE_ONE, ends_stream && len == 0);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 8) begin
            // emulation prevention pattern, followed by whatever payload comes next
            send_byte(BYTE_ZERO, 1'b0);
            send_byte(BYTE_ZERO, 1'b0);
            send_byte(BYTE_EPB, 1'b0);
         end
         send_byte(payload_byte(), ends_stream && i == len - 1);
      end
      units_sent++;
   endtask

   // Unstructured bytes, including broken start codes and stray flushes.
   task automatic send_noise();
      int n;
      n = $urandom_range(6, 1);
      repeat (n) send_byte(payload_byte(), $urandom_range(99) < 5);
   endtask

   task automatic random_stream(input int target);
      int len;
      while (bytes_sent < target) begin
         if ($urandom_range(99) < 10) begin
            send_noise();
         end else begin
            case ($urandom_range(19))
               0:       len = 0;
               1, 2:    len = $urandom_range(30, 13);
               default: len = $urandom_range(12, 1);
            endcase
            send_unit(len, $urandom_range(99) < 12);
         end
      end
   endtask

   // Sender stops until every predicted byte has been taken.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.due_bytes.size() != 0);
   endtask

   task automatic send_list(input logic [7:0] seq[$], input bit flush_at_end);
      foreach (seq[i]) send_byte(seq[i], flush_at_end && i == seq.size() - 1);
   endtask

   // Result side: check every transfer, idle at random, honor one long hold-off.
   initial begin
      int stall_left;
      result_type got;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.out_byte        = rsp_tdata;
            got.first_of_unit   = rsp_tuser[0];
            got.last_of_unit    = rsp_tlast;
            got.long_start_code = rsp_tuser[1];
            sb.check_nal_byte(got);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 18);
         end
      end
   end

   // Watchdog: any transfer on either side counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [7:0] seq[$];
      int base;
      sb           = new();
      calm         = 1'b0;
      hold_request = 1'b0;
      bytes_sent   = 0;
      units_sent   = 0;
      flushes      = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: junk before the first start code, short code, extreme payload bytes,
      // emulation prevention, stray 00 00 02, long code directly followed by another
      // start code (empty unit), a run of four zeros, flush on a pending zero.
      seq = '{8'hFF, 8'h00, 8'h00, 8'h01, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h03, 8'h01,
              8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01,
              8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h00};
      send_list(seq, 1'b1);
      // flush arriving on a start code closes the unit before it
      seq = '{8'h00, 8'h00, 8'h01, 8'hAA, 8'h00, 8'h00, 8'h01};
      send_list(seq, 1'b1);
      wait_drained();
      base = bytes_sent;

      random_stream(base + RANDOM_BYTES / 3);

      // Receiver holds off while the sender streams a long unit without gaps:
      // the result queue fills and req_tready must drop.
      hold_request = 1'b1;
      calm = 1'b1;
      send_unit(48, 1'b0);
      calm = 1'b0;
      wait_drained();

      // Stretch with no idling on either side.
      calm = 1'b1;
      random_stream(bytes_sent + 40);
      calm = 1'b0;

      random_stream(base + RANDOM_BYTES);
      send_unit(4, 1'b1);   // flush whatever unit is still open

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (sb.due_bytes.size() != 0) begin
         $error("%0d predicted NAL bytes never arrived", sb.due_bytes.size());
         sb.errors++;
      end

      $display("Run: %0d stream bytes, %0d random start-coded units, %0d end-of-stream flushes,",
               bytes_sent, units_sent, flushes);
      $display("     %0d NAL bytes checked, including a full-queue input stall.", sb.matched);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/anxb_pkg.sv
hdl/anxb_parser.sv
hdl/anxb_fifo.sv
hdl/annexb_nal_unit_extractor_top.sv
sim/tb_top.sv
